### rtl/core/odq_pkg.sv
// shared types, constants and helper functions for the dither quantizer
package odq_pkg;

  typedef enum logic [2:0] {
    FMT_RGB565  = 3'd0,
    FMT_RGB555  = 3'd1,
    FMT_RGB332  = 3'd2,
    FMT_CUBE216 = 3'd3,
    FMT_PASTEL  = 3'd4,
    FMT_COL16   = 3'd5,
    FMT_RGB121  = 3'd6,
    FMT_NONE    = 3'd7
  } fmt_t;

  typedef enum logic {
    REG_FORMAT = 1'b0,
    REG_SHIFT  = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    CLS_CUBE  = 2'd0,
    CLS_GREEN = 2'd1,
    CLS_BROWN = 2'd2,
    CLS_GREY  = 2'd3
  } cls_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [1:0] dither_phase;
  } in_word_t;

  typedef struct packed {
    logic [15:0] pixel_code;
    logic        table_miss;
  } out_word_t;

  typedef struct packed {
    fmt_t       fmt;
    logic [1:0] sh;
    logic [1:0] n;
  } ctl_t;

  localparam int NUM_HUES = 21;

  // per hue: red face g lo,hi b lo,hi; green face r lo,hi b lo,hi; blue face r lo,hi g lo,hi
  function automatic logic [7:0] hue_face(input logic [4:0] k, input logic [3:0] j);
    logic [95:0] row;
    row = 96'hff00ff00_ff00ff00_ff00ff00;
    case (k)
      5'd0:  row = 96'ha0e055a0_ff00ff00_ff00ff00;
      5'd1:  row = 96'ha0e8a0d8_ff00ff00_ff00ff00;
      5'd2:  row = 96'hff00ff00_ff00ff00_00550055;
      5'd3:  row = 96'hff00ff00_ff00ff00_005555aa;
      5'd4:  row = 96'hff00ff00_ff00ff00_55aa0055;
      5'd5:  row = 96'hff00ff00_ff00ff00_55aa55aa;
      5'd6:  row = 96'hff00ff00_00550055_ff00ff00;
      5'd7:  row = 96'hff00ff00_005555aa_ff00ff00;
      5'd8:  row = 96'hff00ff00_55aa0055_ff00ff00;
      5'd9:  row = 96'hff00ff00_55aa55aa_ff00ff00;
      5'd10: row = 96'hff00ff00_0055aaff_0055aaff;
      5'd11: row = 96'hff00ff00_55aaaaff_55aaaaff;
      5'd12: row = 96'h00550055_ff00ff00_ff00ff00;
      5'd13: row = 96'h005555aa_ff00ff00_ff00ff00;
      5'd14: row = 96'h55aa0055_ff00ff00_ff00ff00;
      5'd15: row = 96'h55aa55aa_ff00ff00_ff00ff00;
      5'd16: row = 96'h0055aaff_ff00ff00_aaff0055;
      5'd17: row = 96'h55aaaaff_ff00ff00_aaff55aa;
      5'd18: row = 96'haaff0055_aaff0055_ff00ff00;
      5'd19: row = 96'haaff55aa_aaff55c7_ff00ff00;
      5'd20: row = 96'haaffaaff_aaffc7ff_aaffaaff;
      default: row = 96'hff00ff00_ff00ff00_ff00ff00;
    endcase
    return row[8'd95 - {j, 3'b000} -: 8];
  endfunction

  // v*255/31 rounded down: v*8 plus floor(7v/31)
  function automatic logic [7:0] widen5(input logic [4:0] v);
    logic [2:0] f;
    f = {2'd0, v >= 5'd5} + {2'd0, v >= 5'd9} + {2'd0, v >= 5'd14} + {2'd0, v >= 5'd18}
      + {2'd0, v >= 5'd23} + {2'd0, v >= 5'd27} + {2'd0, v >= 5'd31};
    return {v, 3'd0} + {5'd0, f};
  endfunction

  function automatic logic [15:0] times255(input logic [7:0] c);
    return ({8'd0, c} << 8) - {8'd0, c};
  endfunction

  // floor(n/d) >= k, with n = c*255 and c <= d
  function automatic logic q_ge(input logic [15:0] n, input logic [7:0] d,
                                input logic [7:0] k);
    return {1'b0, n} >= {9'd0, k} * {9'd0, d};
  endfunction

  // floor(n/d) <= k, with n = c*255 and c <= d
  function automatic logic q_le(input logic [15:0] n, input logic [7:0] d,
                                input logic [7:0] k);
    return {1'b0, n} < ({9'd0, k} + 17'd1) * {9'd0, d};
  endfunction

  // palette band ((v*bands)>>5 + n) >> sh
  function automatic logic [7:0] pal_band(input logic [4:0] v, input logic [6:0] bands,
                                          input logic [1:0] n, input logic [1:0] sh);
    logic [11:0] p;
    logic [7:0]  t;
    p = {7'd0, v} * {5'd0, bands};
    t = {1'b0, p[11:5]} + {6'd0, n};
    return t >> sh;
  endfunction

  // hicolor band with zero clamp; bands = num*32 or num*64
  function automatic logic [5:0] hi_band(input logic [7:0] i, input logic [2:0] num,
                                         input logic wide, input logic [1:0] n,
                                         input logic [1:0] sh);
    logic [15:0] p;
    logic [8:0]  t;
    p = {8'd0, i} * ({13'd0, num} << (wide ? 6 : 5));
    t = {1'b0, p[15:8]} + {7'd0, n};
    if (t < {6'd0, num} - 9'd1) return '0;
    return 6'((t - ({6'd0, num} - 9'd1)) >> sh);
  endfunction

endpackage

### rtl/core/ordered_dither_palette_quantizer.sv
// top level: config registers and three-stage quantizer pipeline
// an accepted word is registered by the band, hue search and pack stages in turn before it appears on out_
// throughput: one word per clock; busy is never high
// the pipeline depth is set by band, hue search and pack stages
// reset: format rgb565, dither shift 2, pipeline empty
module ordered_dither_palette_quantizer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  odq_pkg::in_word_t  in_word,
  output logic               out_strobe,
  output odq_pkg::out_word_t out_word,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [2:0]         cfg_data
);

  odq_pkg::fmt_t fmt_r;
  logic [1:0]    sh_r;
  odq_pkg::ctl_t ctl;
  logic          acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= odq_pkg::FMT_RGB565;
      sh_r  <= 2'd2;
    end else if (cfg_valid && cfg_ready) begin
      unique case (odq_pkg::reg_idx_t'(cfg_index))
        odq_pkg::REG_FORMAT: fmt_r <= odq_pkg::fmt_t'(cfg_data);
        odq_pkg::REG_SHIFT:  sh_r  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;
  assign busy = 1'b0;
  assign acc = start && !busy;

  always_comb begin
    ctl.fmt = fmt_r;
    ctl.sh  = (sh_r == 2'd3) ? 2'd2 : sh_r;
    ctl.n   = in_word.dither_phase & 2'((3'd1 << ctl.sh) - 3'd1);
  end

  logic          v1, v2;
  odq_pkg::ctl_t c1, c2;
  logic [15:0]   h1, h2;
  logic [4:0]    m1, m2, hue2;
  logic [7:0]    pr1, pg1, pb1, cd1, pr2, pg2, pb2;
  logic [15:0]   cr1, cg1, cb1;
  logic          miss2;
  odq_pkg::cls_t cls2;

  odq_front u_front (
    .clk, .rst_n, .vld_i(acc), .word_i(in_word), .ctl_i(ctl),
    .vld_o(v1), .ctl_o(c1), .hicode_o(h1), .m5_o(m1),
    .pr_o(pr1), .pg_o(pg1), .pb_o(pb1), .cr_o(cr1), .cg_o(cg1), .cb_o(cb1), .cd_o(cd1)
  );

  odq_classify u_cls (
    .clk, .rst_n, .vld_i(v1), .ctl_i(c1), .hicode_i(h1), .m5_i(m1),
    .pr_i(pr1), .pg_i(pg1), .pb_i(pb1), .cr_i(cr1), .cg_i(cg1), .cb_i(cb1), .cd_i(cd1),
    .vld_o(v2), .ctl_o(c2), .hicode_o(h2), .m5_o(m2),
    .pr_o(pr2), .pg_o(pg2), .pb_o(pb2), .hue_o(hue2), .miss_o(miss2), .cls_o(cls2)
  );

  odq_pack u_pack (
    .clk, .rst_n, .vld_i(v2), .ctl_i(c2), .hicode_i(h2), .m5_i(m2),
    .pr_i(pr2), .pg_i(pg2), .pb_i(pb2), .hue_i(hue2), .miss_i(miss2), .cls_i(cls2),
    .vld_o(out_strobe), .word_o(out_word)
  );

endmodule

### rtl/core/odq_front.sv
// stage 1: channel bands and scaled channels for the cube face tests
module odq_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              vld_i,
  input  odq_pkg::in_word_t word_i,
  input  odq_pkg::ctl_t     ctl_i,
  output logic              vld_o,
  output odq_pkg::ctl_t     ctl_o,
  output logic [15:0]       hicode_o,
  output logic [4:0]        m5_o,
  output logic [7:0]        pr_o,
  output logic [7:0]        pg_o,
  output logic [7:0]        pb_o,
  output logic [15:0]       cr_o,
  output logic [15:0]       cg_o,
  output logic [15:0]       cb_o,
  output logic [7:0]        cd_o
);

  logic        vld_r;
  odq_pkg::ctl_t ctl_r;
  logic [15:0] hicode_r, hicode_nxt;
  logic [4:0]  m5_r, m5_nxt;
  logic [7:0]  pr_r, pg_r, pb_r, cd_r;
  logic [7:0]  pr_nxt, pg_nxt, pb_nxt, cd_nxt;
  logic [15:0] cr_r, cg_r, cb_r, cr_nxt, cg_nxt, cb_nxt;

  always_comb begin
    logic [4:0] r5, g5, b5;
    logic [2:0] num;
    logic [6:0] b1, b3, b5c, b7;
    logic [5:0] hr, hg, hb;
    logic [7:0] er, eg, eb, em;
    r5 = word_i.red[7:3];
    g5 = word_i.green[7:3];
    b5 = word_i.blue[7:3];
    num = 3'd1 << ctl_i.sh;
    b1  = 7'd1 + {4'd0, num};
    b3  = 7'd1 + 7'({4'd0, num} * 7'd3);
    b5c = 7'd1 + 7'({4'd0, num} * 7'd5);
    b7  = 7'd1 + 7'({4'd0, num} * 7'd7);
    m5_nxt = (r5 > g5) ? r5 : g5;
    m5_nxt = (b5 > m5_nxt) ? b5 : m5_nxt;
    hr = odq_pkg::hi_band(word_i.red, num, 1'b0, ctl_i.n, ctl_i.sh);
    hg = odq_pkg::hi_band(word_i.green, num, ctl_i.fmt == odq_pkg::FMT_RGB565,
                          ctl_i.n, ctl_i.sh);
    hb = odq_pkg::hi_band(word_i.blue, num, 1'b0, ctl_i.n, ctl_i.sh);
    hicode_nxt = '0;
    pr_nxt = '0; pg_nxt = '0; pb_nxt = '0;
    case (ctl_i.fmt)
      odq_pkg::FMT_RGB565: hicode_nxt = {hr[4:0], hg, hb[4:0]};
      odq_pkg::FMT_RGB555: hicode_nxt = {1'b0, hr[4:0], hg[4:0], hb[4:0]};
      odq_pkg::FMT_RGB332: begin
        pr_nxt = odq_pkg::pal_band(r5, b7, ctl_i.n, ctl_i.sh);
        pg_nxt = odq_pkg::pal_band(g5, b7, ctl_i.n, ctl_i.sh);
        pb_nxt = odq_pkg::pal_band(b5, b3, ctl_i.n, ctl_i.sh);
      end
      odq_pkg::FMT_CUBE216: begin
        pr_nxt = odq_pkg::pal_band(r5, b5c, ctl_i.n, ctl_i.sh);
        pg_nxt = odq_pkg::pal_band(g5, b5c, ctl_i.n, ctl_i.sh);
        pb_nxt = odq_pkg::pal_band(b5, b5c, ctl_i.n, ctl_i.sh);
      end
      odq_pkg::FMT_COL16: begin
        pr_nxt = odq_pkg::pal_band(r5, b1, ctl_i.n, ctl_i.sh);
        pg_nxt = odq_pkg::pal_band(g5, b1, ctl_i.n, ctl_i.sh);
        pb_nxt = odq_pkg::pal_band(b5, b1, ctl_i.n, ctl_i.sh);
      end
      odq_pkg::FMT_RGB121: begin
        pr_nxt = odq_pkg::pal_band(r5, b1, ctl_i.n, ctl_i.sh);
        pg_nxt = odq_pkg::pal_band(g5, b3, ctl_i.n, ctl_i.sh);
        pb_nxt = odq_pkg::pal_band(b5, b1, ctl_i.n, ctl_i.sh);
      end
      default: ;
    endcase
    // pastel widens the 5-bit channels to 8 bits (v*255/31)
    if (ctl_i.fmt == odq_pkg::FMT_PASTEL) begin
      er = odq_pkg::widen5(r5);
      eg = odq_pkg::widen5(g5);
      eb = odq_pkg::widen5(b5);
      em = odq_pkg::widen5(m5_nxt);
    end else begin
      er = {3'd0, r5};
      eg = {3'd0, g5};
      eb = {3'd0, b5};
      em = {3'd0, m5_nxt};
    end
    cr_nxt = odq_pkg::times255(er);
    cg_nxt = odq_pkg::times255(eg);
    cb_nxt = odq_pkg::times255(eb);
    cd_nxt = em;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
    ctl_r    <= ctl_i;
    hicode_r <= hicode_nxt;
    m5_r     <= m5_nxt;
    pr_r <= pr_nxt; pg_r <= pg_nxt; pb_r <= pb_nxt;
    cr_r <= cr_nxt; cg_r <= cg_nxt; cb_r <= cb_nxt; cd_r <= cd_nxt;
  end

  assign vld_o = vld_r;
  assign ctl_o = ctl_r;
  assign hicode_o = hicode_r;
  assign m5_o = m5_r;
  assign pr_o = pr_r; assign pg_o = pg_r; assign pb_o = pb_r;
  assign cr_o = cr_r; assign cg_o = cg_r; assign cb_o = cb_r; assign cd_o = cd_r;

endmodule

### rtl/core/odq_classify.sv
// stage 2: hue search and col16 class decision
module odq_classify (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          vld_i,
  input  odq_pkg::ctl_t ctl_i,
  input  logic [15:0]   hicode_i,
  input  logic [4:0]    m5_i,
  input  logic [7:0]    pr_i,
  input  logic [7:0]    pg_i,
  input  logic [7:0]    pb_i,
  input  logic [15:0]   cr_i,
  input  logic [15:0]   cg_i,
  input  logic [15:0]   cb_i,
  input  logic [7:0]    cd_i,
  output logic          vld_o,
  output odq_pkg::ctl_t ctl_o,
  output logic [15:0]   hicode_o,
  output logic [4:0]    m5_o,
  output logic [7:0]    pr_o,
  output logic [7:0]    pg_o,
  output logic [7:0]    pb_o,
  output logic [4:0]    hue_o,
  output logic          miss_o,
  output odq_pkg::cls_t cls_o
);

  logic          vld_r;
  odq_pkg::ctl_t ctl_r;
  logic [15:0]   hicode_r;
  logic [4:0]    m5_r, hue_r, hue_nxt;
  logic [7:0]    pr_r, pg_r, pb_r;
  logic          miss_r, miss_nxt;
  odq_pkg::cls_t cls_r, cls_nxt;

  always_comb begin
    logic found, hit;
    found = 1'b0;
    hue_nxt = '0;
    for (int k = 0; k < odq_pkg::NUM_HUES; k++) begin
      hit = (odq_pkg::q_ge(cr_i, cd_i, 8'hff)
             && odq_pkg::q_ge(cg_i, cd_i, odq_pkg::hue_face(5'(k), 4'd0))
             && odq_pkg::q_le(cg_i, cd_i, odq_pkg::hue_face(5'(k), 4'd1))
             && odq_pkg::q_ge(cb_i, cd_i, odq_pkg::hue_face(5'(k), 4'd2))
             && odq_pkg::q_le(cb_i, cd_i, odq_pkg::hue_face(5'(k), 4'd3)))
         || (odq_pkg::q_ge(cg_i, cd_i, 8'hff)
             && odq_pkg::q_ge(cr_i, cd_i, odq_pkg::hue_face(5'(k), 4'd4))
             && odq_pkg::q_le(cr_i, cd_i, odq_pkg::hue_face(5'(k), 4'd5))
             && odq_pkg::q_ge(cb_i, cd_i, odq_pkg::hue_face(5'(k), 4'd6))
             && odq_pkg::q_le(cb_i, cd_i, odq_pkg::hue_face(5'(k), 4'd7)))
         || (odq_pkg::q_ge(cb_i, cd_i, 8'hff)
             && odq_pkg::q_ge(cr_i, cd_i, odq_pkg::hue_face(5'(k), 4'd8))
             && odq_pkg::q_le(cr_i, cd_i, odq_pkg::hue_face(5'(k), 4'd9))
             && odq_pkg::q_ge(cg_i, cd_i, odq_pkg::hue_face(5'(k), 4'd10))
             && odq_pkg::q_le(cg_i, cd_i, odq_pkg::hue_face(5'(k), 4'd11)));
      if (hit && !found) begin
        found = 1'b1;
        hue_nxt = 5'(k);
      end
    end
    miss_nxt = (ctl_i.fmt == odq_pkg::FMT_PASTEL) && (m5_i != 5'd0) && !found;
    if (odq_pkg::q_ge(cg_i, cd_i, 8'hff) && odq_pkg::q_le(cr_i, cd_i, 8'he0)
        && odq_pkg::q_le(cb_i, cd_i, 8'he0))
      cls_nxt = odq_pkg::CLS_GREEN;
    else if (odq_pkg::q_ge(cr_i, cd_i, 8'hff) && odq_pkg::q_le(cb_i, cd_i, 8'hd8)
             && odq_pkg::q_ge(cg_i, cd_i, 8'h90) && odq_pkg::q_le(cg_i, cd_i, 8'he8))
      cls_nxt = odq_pkg::CLS_BROWN;
    else if ((odq_pkg::q_ge(cr_i, cd_i, 8'hff) && odq_pkg::q_ge(cb_i, cd_i, 8'hb0)
              && odq_pkg::q_ge(cg_i, cd_i, 8'hb0)) ||
             (odq_pkg::q_ge(cb_i, cd_i, 8'hff) && odq_pkg::q_ge(cr_i, cd_i, 8'hb0)
              && odq_pkg::q_ge(cg_i, cd_i, 8'hb0)) ||
             (odq_pkg::q_ge(cg_i, cd_i, 8'hff) && odq_pkg::q_ge(cr_i, cd_i, 8'hb0)
              && odq_pkg::q_ge(cb_i, cd_i, 8'hb0)))
      cls_nxt = odq_pkg::CLS_GREY;
    else
      cls_nxt = odq_pkg::CLS_CUBE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
    ctl_r <= ctl_i; hicode_r <= hicode_i; m5_r <= m5_i;
    pr_r <= pr_i; pg_r <= pg_i; pb_r <= pb_i;
    hue_r <= hue_nxt; miss_r <= miss_nxt; cls_r <= cls_nxt;
  end

  assign vld_o = vld_r;
  assign ctl_o = ctl_r;
  assign hicode_o = hicode_r;
  assign m5_o = m5_r;
  assign pr_o = pr_r; assign pg_o = pg_r; assign pb_o = pb_r;
  assign hue_o = hue_r;
  assign miss_o = miss_r;
  assign cls_o = cls_r;

endmodule

### rtl/core/odq_pack.sv
// stage 3: level banding and final code assembly
module odq_pack (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               vld_i,
  input  odq_pkg::ctl_t      ctl_i,
  input  logic [15:0]        hicode_i,
  input  logic [4:0]         m5_i,
  input  logic [7:0]         pr_i,
  input  logic [7:0]         pg_i,
  input  logic [7:0]         pb_i,
  input  logic [4:0]         hue_i,
  input  logic               miss_i,
  input  odq_pkg::cls_t      cls_i,
  output logic               vld_o,
  output odq_pkg::out_word_t word_o
);

  logic               vld_r;
  odq_pkg::out_word_t word_r, word_nxt;

  always_comb begin
    logic [2:0]  num;
    logic [7:0]  pl;
    logic [15:0] code;
    num = 3'd1 << ctl_i.sh;
    pl = '0;
    code = '0;
    case (ctl_i.fmt)
      odq_pkg::FMT_RGB565, odq_pkg::FMT_RGB555: code = hicode_i;
      odq_pkg::FMT_RGB332: code = 16'({pr_i, 5'd0} | {pg_i, 2'd0} | {8'd0, pb_i});
      odq_pkg::FMT_CUBE216:
        code = 16'(({8'd0, pr_i} * 16'd6 + {8'd0, pg_i}) * 16'd6 + {8'd0, pb_i});
      odq_pkg::FMT_PASTEL: begin
        pl = odq_pkg::pal_band(m5_i, 7'd1 + 7'({4'd0, num} * 7'd12), ctl_i.n, ctl_i.sh);
        code = (pl == 8'd0) ? 16'd0
             : 16'(16'd1 + {11'd0, hue_i} * 16'd12 + {8'd0, pl} - 16'd1);
      end
      odq_pkg::FMT_COL16: begin
        if (m5_i == 5'd0) code = '0;
        else case (cls_i)
          odq_pkg::CLS_GREEN: begin
            pl = odq_pkg::pal_band(m5_i, 7'd1 + 7'({4'd0, num} * 7'd2), ctl_i.n, ctl_i.sh);
            code = (pl == 8'd0) ? 16'd0 : (pl == 8'd1) ? 16'd13 : 16'd2;
          end
          odq_pkg::CLS_BROWN: begin
            pl = odq_pkg::pal_band(m5_i, 7'd1 + 7'({4'd0, num} * 7'd2), ctl_i.n, ctl_i.sh);
            code = (pl == 8'd0) ? 16'd0 : (pl == 8'd1) ? 16'd14 : 16'd15;
          end
          odq_pkg::CLS_GREY: begin
            pl = odq_pkg::pal_band(m5_i, 7'd1 + 7'({4'd0, num} * 7'd6), ctl_i.n, ctl_i.sh);
            case (pl)
              8'd0: code = 16'd0;
              8'd1: code = 16'd8;
              8'd2: code = 16'd9;
              8'd3: code = 16'd10;
              8'd4: code = 16'd11;
              8'd5: code = 16'd12;
              default: code = 16'd7;
            endcase
          end
          default: code = 16'(({8'd0, pr_i} * 16'd2 + {8'd0, pg_i}) * 16'd2 + {8'd0, pb_i});
        endcase
      end
      odq_pkg::FMT_RGB121: code = 16'({pr_i, 3'd0} | {pg_i, 1'b0} | {8'd0, pb_i});
      default: code = '0;
    endcase
    word_nxt.pixel_code = code;
    word_nxt.table_miss = miss_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
    word_r <= word_nxt;
  end

  assign vld_o = vld_r;
  assign word_o = word_r;

  a_miss_pastel: assert property (@(posedge clk) disable iff (!rst_n)
    vld_i && miss_i |-> ctl_i.fmt == odq_pkg::FMT_PASTEL)
    else $error("miss outside pastel");
  a_vld_follow: assert property (@(posedge clk) disable iff (!rst_n)
    vld_i |=> vld_o)
    else $error("valid lost");
  a_hold_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    vld_o && ctl_i.fmt == odq_pkg::FMT_NONE && vld_i |=> word_o.pixel_code == 16'd0)
    else $error("unknown format gives nonzero code");

endmodule
